>>> design/koch_segment_subdivider_unit_defines.svh
// ----------------------------------------------------------------------------
// Koch segment subdivider: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KOCH_SEGMENT_SUBDIVIDER_UNIT_DEFINES_SVH
`define KOCH_SEGMENT_SUBDIVIDER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KSDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ksds_pkg.sv
// ----------------------------------------------------------------------------
// ksds_pkg
// Types and constants shared by the Koch segment subdivider modules.
// ----------------------------------------------------------------------------
package ksds_pkg;

	// point order within one segment, also the point_index output code
	typedef enum logic [2:0] {
		PT_START      = 3'd0,
		PT_THIRD      = 3'd1,
		PT_APEX       = 3'd2,
		PT_TWO_THIRDS = 3'd3,
		PT_END        = 3'd4
	} pt_idx_t;

	typedef enum logic [1:0] {
		CFG_SCALE    = 2'd0,
		CFG_OFFSET_X = 2'd1,
		CFG_OFFSET_Y = 2'd2
	} cfg_reg_t;

	// control tag that travels with each point down the pipeline
	typedef struct packed {
		logic    valid;
		pt_idx_t idx;
	} pt_tag_t;

	localparam logic [31:0] SCALE_RESET = 32'd65536;

	// 1/(2*sqrt3) in unsigned Q0.32
	localparam logic [30:0] KOCH_K = 31'd1239850262;

	// Divide-by-3 of a 35-bit word split into an 18-bit high and 17-bit low part.
	localparam int DIV3_HI_W = 18;
	localparam int DIV3_LO_W = 17;
	localparam logic [17:0] DIV3_M_HI = 18'((2 ** (DIV3_HI_W + 1) + 2) / 3);
	localparam logic [16:0] DIV3_M_LO = 17'((2 ** (DIV3_LO_W + 1) + 2) / 3);
	// 2^17 = 3 * TWO17_DIV3 + 2
	localparam logic [15:0] TWO17_DIV3 = 16'((2 ** DIV3_LO_W) / 3);
	// bias that makes the dividend non-negative: 3 * 2^32, removed as 2^32
	localparam logic [34:0] DIV3_BIAS   = 35'h3_0000_0000;
	localparam logic [34:0] DIV3_OFFSET = 35'h1_0000_0000;

endpackage

>>> design/ksds_channels.sv
// ----------------------------------------------------------------------------
// Koch segment subdivider channels
// Valid/ready interfaces for the segment input and the point output.
// ----------------------------------------------------------------------------
interface ksds_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_re;
	logic signed [31:0] start_im;
	logic signed [31:0] end_re;
	logic signed [31:0] end_im;

	modport source (output valid, start_re, start_im, end_re, end_im, input ready);
	modport sink   (input valid, start_re, start_im, end_re, end_im, output ready);
endinterface

interface ksds_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_re;
	logic signed [31:0] point_im;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic        [2:0]  point_index;
	logic               last;

	modport source (output valid, point_re, point_im, pixel_x, pixel_y, point_index, last,
		input ready);
	modport sink   (input valid, point_re, point_im, pixel_x, pixel_y, point_index, last,
		output ready);
endinterface

>>> design/ksds_point_gen.sv
// ----------------------------------------------------------------------------
// ksds_point_gen
// Two-stage geometry, one Koch point per cycle while adv holds: endpoints
// pass through, third points by a split reciprocal divide-by-3, apex by
// the 1/(2*sqrt3) multiply with two half-away roundings and saturation.
// ----------------------------------------------------------------------------
module ksds_point_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  ksds_pkg::pt_tag_t  tag_in,
	input  logic signed [31:0] sr,
	input  logic signed [31:0] si,
	input  logic signed [31:0] er,
	input  logic signed [31:0] ei,
	output ksds_pkg::pt_tag_t  tag_out,
	output logic signed [31:0] pt_re,
	output logic signed [31:0] pt_im
);
	import ksds_pkg::*;

	pt_tag_t            tag_s1;
	pt_tag_t            tag_s2;
	logic signed [31:0] pt_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [31:0] s_v;
		logic signed [31:0] e_v;
		logic signed [31:0] a_v;
		logic signed [31:0] b_v;
		logic signed [31:0] base_v;
		logic signed [32:0] dperp;
		logic signed [32:0] d3;
		logic signed [33:0] t3;
		logic        [34:0] w3;
		logic        [35:0] prod_hi;
		logic        [33:0] prod_lo;
		logic signed [63:0] prod_ap;

		logic signed [31:0] base_s1;
		logic        [17:0] hi_s1;
		logic        [16:0] lo_s1;
		logic        [16:0] q1_s1;
		logic        [15:0] q2_s1;
		logic signed [63:0] ap_s1;
		logic signed [32:0] se_s1;

		logic        [1:0]  r1;
		logic        [1:0]  r2;
		logic        [2:0]  tt;
		logic        [1:0]  corr;
		logic        [34:0] qw;
		logic        [34:0] third;
		logic        [63:0] ap_rnd;
		logic signed [32:0] half;
		logic signed [33:0] sum2;
		logic        [33:0] v_rnd;
		logic signed [32:0] v;
		logic signed [31:0] apex;
		logic signed [31:0] pt_c;

		// lane 0 is x, lane 1 is y; perpendicular is (s_im - e_im, e_re - s_re)
		assign s_v   = (l == 0) ? sr : si;
		assign e_v   = (l == 0) ? er : ei;
		assign dperp = (l == 0) ? (33'(si) - 33'(ei)) : (33'(er) - 33'(sr));

		// (2a+b)/3 = a + nearest((b-a)/3) = a + floor((b-a+1)/3)
		assign a_v    = (tag_in.idx == PT_THIRD) ? s_v : e_v;
		assign b_v    = (tag_in.idx == PT_THIRD) ? e_v : s_v;
		assign base_v = (tag_in.idx == PT_START || tag_in.idx == PT_THIRD) ? s_v : e_v;
		assign d3     = 33'(b_v) - 33'(a_v);
		assign t3     = 34'(d3) + 34'sd1;
		assign w3     = 35'(t3) + DIV3_BIAS;

		assign prod_hi = 36'(w3[34:17]) * 36'(DIV3_M_HI);
		assign prod_lo = 34'(w3[16:0]) * 34'(DIV3_M_LO);
		assign prod_ap = dperp * $signed({1'b0, KOCH_K});

		always_ff @(posedge clk) begin
			if (adv) begin
				base_s1 <= base_v;
				hi_s1   <= w3[34:17];
				lo_s1   <= w3[16:0];
				q1_s1   <= prod_hi[35:19];
				q2_s1   <= prod_lo[33:18];
				ap_s1   <= prod_ap;
				se_s1   <= 33'(s_v) + 33'(e_v);
			end
		end

		// recombine the two partial quotients, fold the remainders back in
		assign r1    = 2'(hi_s1 - 18'({q1_s1, 1'b0}) - 18'(q1_s1));
		assign r2    = 2'(lo_s1 - 17'({q2_s1, 1'b0}) - 17'(q2_s1));
		assign tt    = {r1, 1'b0} + 3'(r2);
		assign corr  = (tt >= 3'd6) ? 2'd2 : ((tt >= 3'd3) ? 2'd1 : 2'd0);
		assign qw    = 35'({q1_s1, 17'd0}) + 35'(r1) * 35'(TWO17_DIV3) + 35'(q2_s1)
			+ 35'(corr);
		assign third = 35'(base_s1) + qw - DIV3_OFFSET;

		// half-away rounding: add half, minus one when negative, then floor
		assign ap_rnd = ap_s1 + 64'h4000_0000 - {63'd0, ap_s1[63]};
		assign half   = $signed(ap_rnd[63:31]);
		assign sum2   = 34'(se_s1) + 34'(half);
		assign v_rnd  = sum2 + 34'd1 - {33'd0, sum2[33]};
		assign v      = $signed(v_rnd[33:1]);
		assign apex   = (v[32] != v[31]) ? (v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: v[31:0];

		always_comb begin
			case (tag_s1.idx)
				PT_THIRD, PT_TWO_THIRDS: pt_c = third[31:0];
				PT_APEX:                 pt_c = apex;
				default:                 pt_c = base_s1;
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s2[l] <= pt_c;
			end
		end
	end

	assign tag_out = tag_s2;
	assign pt_re   = pt_s2[0];
	assign pt_im   = pt_s2[1];

endmodule

>>> design/ksds_pixel_map.sv
// ----------------------------------------------------------------------------
// ksds_pixel_map
// Scales a point to pixels: Q16.16 x Q16.16 product, half-away rounding to
// an integer, offset add and saturation to 16 bits. Stage 4 is the result
// register seen on the output channel.
// ----------------------------------------------------------------------------
module ksds_pixel_map (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  ksds_pkg::pt_tag_t  tag_in,
	input  logic signed [31:0] pt_re,
	input  logic signed [31:0] pt_im,
	input  logic        [31:0] scale,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	output ksds_pkg::pt_tag_t  tag_out,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic signed [15:0] pix_x,
	output logic signed [15:0] pix_y
);
	import ksds_pkg::*;

	pt_tag_t            tag_s3;
	pt_tag_t            tag_s4;
	logic signed [31:0] pt_s4  [2];
	logic signed [15:0] pix_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s3 <= tag_in;
			tag_s4 <= tag_s3;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [31:0] p_v;
		logic signed [15:0] off_v;
		logic signed [63:0] prod;
		logic signed [31:0] pt_s3;
		logic signed [63:0] prod_s3;
		logic        [63:0] rnd;
		logic signed [31:0] r;
		logic signed [32:0] sum;
		logic signed [15:0] pix_c;

		assign p_v   = (l == 0) ? pt_re : pt_im;
		assign off_v = (l == 0) ? offset_x : offset_y;
		assign prod  = p_v * $signed({1'b0, scale});

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s3   <= p_v;
				prod_s3 <= prod;
			end
		end

		assign rnd = prod_s3 + 64'h8000_0000 - {63'd0, prod_s3[63]};
		assign r   = $signed(rnd[63:32]);
		assign sum = 33'(r) + 33'(off_v);

		always_comb begin
			if (sum > 33'sd32767) begin
				pix_c = 16'sh7FFF;
			end else if (sum < -33'sd32768) begin
				pix_c = 16'sh8000;
			end else begin
				pix_c = sum[15:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s4[l]  <= pt_s3;
				pix_s4[l] <= pix_c;
			end
		end
	end

	assign tag_out = tag_s4;
	assign out_re  = pt_s4[0];
	assign out_im  = pt_s4[1];
	assign pix_x   = pix_s4[0];
	assign pix_y   = pix_s4[1];

endmodule

>>> design/koch_segment_subdivider_unit.sv
// ----------------------------------------------------------------------------
// koch_segment_subdivider_unit
// Splits a segment into its five Koch points with pixel coordinates.
//
//   channel  side  payload
//   seg      in    start_re, start_im, end_re, end_im (Q16.16)
//   pt       out   point_re, point_im, pixel_x, pixel_y, point_index, last
//   cfg      in    cfg_wr_en, cfg_index, cfg_wdata (scale, offset_x, offset_y)
//
// The output carries one point per cycle while pt is not stalled, and the
// segment register issues points start through end in that order.
// The first point of a segment is offered on pt four pipeline stages behind
// the segment register.
// Reset clears the valid bits and loads scale 1.0 and zero offsets.
// A stall on pt freezes the whole pipeline; the next segment is taken in the
// same cycle its predecessor's end point issues.
// ----------------------------------------------------------------------------
`include "koch_segment_subdivider_unit_defines.svh"

module koch_segment_subdivider_unit (
	input  logic        clk,
	input  logic        arst_n,
	ksds_seg_if.sink    seg,
	ksds_pt_if.source   pt,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import ksds_pkg::*;

	logic               seg_vld_q;
	pt_idx_t            idx_q;
	logic signed [31:0] sr_q;
	logic signed [31:0] si_q;
	logic signed [31:0] er_q;
	logic signed [31:0] ei_q;

	logic [31:0]        scale_q;
	logic signed [15:0] off_x_q;
	logic signed [15:0] off_y_q;

	logic               adv;
	pt_tag_t            issue_tag;
	pt_tag_t            geo_tag;
	pt_tag_t            out_tag;
	logic signed [31:0] geo_re;
	logic signed [31:0] geo_im;

	function automatic pt_idx_t next_idx(input pt_idx_t cur);
		pt_idx_t nxt;
		unique case (cur)
			PT_START:      nxt = PT_THIRD;
			PT_THIRD:      nxt = PT_APEX;
			PT_APEX:       nxt = PT_TWO_THIRDS;
			PT_TWO_THIRDS: nxt = PT_END;
			default:       nxt = PT_START;
		endcase
		return nxt;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			off_x_q <= '0;
			off_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SCALE:    scale_q <= cfg_wdata;
				CFG_OFFSET_X: off_x_q <= cfg_wdata[15:0];
				CFG_OFFSET_Y: off_y_q <= cfg_wdata[15:0];
				default:      ;
			endcase
		end
	end

	// pipeline moves whenever the result register is empty or being drained
	assign adv       = !out_tag.valid || pt.ready;
	assign seg.ready = !seg_vld_q || (adv && idx_q == PT_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_vld_q <= 1'b0;
			idx_q     <= PT_START;
		end else if (seg.valid && seg.ready) begin
			seg_vld_q <= 1'b1;
			idx_q     <= PT_START;
		end else if (adv && seg_vld_q) begin
			if (idx_q == PT_END) begin
				seg_vld_q <= 1'b0;
			end
			idx_q <= next_idx(idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			sr_q <= seg.start_re;
			si_q <= seg.start_im;
			er_q <= seg.end_re;
			ei_q <= seg.end_im;
		end
	end

	assign issue_tag.valid = seg_vld_q;
	assign issue_tag.idx   = idx_q;

	ksds_point_gen u_point_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tag_in  (issue_tag),
		.sr      (sr_q),
		.si      (si_q),
		.er      (er_q),
		.ei      (ei_q),
		.tag_out (geo_tag),
		.pt_re   (geo_re),
		.pt_im   (geo_im)
	);

	ksds_pixel_map u_pixel_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tag_in   (geo_tag),
		.pt_re    (geo_re),
		.pt_im    (geo_im),
		.scale    (scale_q),
		.offset_x (off_x_q),
		.offset_y (off_y_q),
		.tag_out  (out_tag),
		.out_re   (pt.point_re),
		.out_im   (pt.point_im),
		.pix_x    (pt.pixel_x),
		.pix_y    (pt.pixel_y)
	);

	assign pt.valid       = out_tag.valid;
	assign pt.point_index = out_tag.idx;
	assign pt.last        = (out_tag.idx == PT_END);

	`KSDS_ASSERT_NEXT(a_seg_hold, clk, arst_n, seg_vld_q && !adv,
		seg_vld_q && $stable(idx_q), "segment dropped or point skipped during stall")
	`KSDS_ASSERT_NEXT(a_seg_start, clk, arst_n, seg.valid && seg.ready,
		seg_vld_q && idx_q == PT_START, "new segment does not start at its first point")
	`KSDS_ASSERT_NOW(a_seg_overlap, clk, arst_n, seg.valid && seg.ready,
		!seg_vld_q || idx_q == PT_END, "segment transfer before previous end point issued")

endmodule
